// File: rtl/psel_pkg.sv
// Shared types and constants for the PUCT child selector.
`default_nettype none
package psel_pkg;

  localparam int MOVE_W   = 13;
  localparam int PRIOR_W  = 16;
  localparam int VIS_W    = 24;
  localparam int TOT_W    = 42;
  localparam int INF_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int SCORE_W  = 32;
  localparam int CNTO_W   = 9;
  localparam int CFG_IDX_W = 2;
  localparam int SQ_IN_W  = 56;
  localparam int SQ_OUT_W = 28;
  localparam int DVD_W    = 48;
  localparam int DVS_W    = 25;
  localparam int EXT_W    = 48;
  localparam int ACC_W    = 27;
  localparam int SUM_W    = 24;
  localparam int SQS_W    = 21;
  localparam int R_W      = 25;
  localparam int E_W      = 32;
  localparam int U_W      = 33;

  localparam logic [GAIN_W-1:0] EXPLORE_RST = 16'd6144;
  localparam logic [GAIN_W-1:0] FPU_RST     = 16'd1229;
  localparam logic signed [EXT_W-1:0] SENTINEL = -48'sd65536000000000;
  localparam logic [ACC_W-1:0] SUM_MAX = 27'h0FF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPLORE = 2'd0,
    CFG_FPU     = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_PQ = 2'd0,
    DIV_U  = 2'd1,
    DIV_Q  = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic [MOVE_W-1:0]  move;
    logic [PRIOR_W-1:0] prior;
    logic [VIS_W-1:0]   visits;
    logic [TOT_W-1:0]   total;
    logic [INF_W-1:0]   inflight;
  } child_t;

  typedef struct packed {
    logic     load_hdr;
    logic     store_child;
    logic     clr_count;
    logic     idx_clr;
    logic     idx_inc;
    logic     sum_clr;
    logic     sum_acc;
    logic     sqrt_start;
    logic     sqrt_sel_n;
    logic     sq_s_ld;
    logic     sq_n_ld;
    logic     div_start;
    div_sel_t div_sel;
    logic     pq_ld;
    logic     gain_ld;
    logic     prod_ld;
    logic     u_ld;
    logic     q_ld;
    logic     best_clr;
    logic     cmp;
    logic     out_ld;
  } psel_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic div_busy;
    logic idx_last;
    logic visited;
  } psel_sts_t;

endpackage
`default_nettype wire

// File: rtl/psel_if.sv
// Request and result channel interfaces of the PUCT child selector.
`default_nettype none
interface psel_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [psel_pkg::VIS_W-1:0]        parent_visits;
  logic signed [psel_pkg::TOT_W-1:0] parent_total;
  logic [psel_pkg::MOVE_W-1:0]       move_id;
  logic [psel_pkg::PRIOR_W-1:0]      prior;
  logic [psel_pkg::VIS_W-1:0]        child_visits;
  logic signed [psel_pkg::TOT_W-1:0] child_total;
  logic [psel_pkg::INF_W-1:0]        pending_vis;
  logic                              last_child;

  modport source (output valid, cmd, parent_visits, parent_total, move_id, prior,
                  child_visits, child_total, pending_vis, last_child, input ready);
  modport sink (input valid, cmd, parent_visits, parent_total, move_id, prior,
                child_visits, child_total, pending_vis, last_child, output ready);
endinterface

interface psel_out_if;
  logic                                valid;
  logic                                ready;
  logic [psel_pkg::MOVE_W-1:0]         best_move;
  logic signed [psel_pkg::SCORE_W-1:0] best_score;
  logic                                found;
  logic [psel_pkg::CNTO_W-1:0]         child_count;

  modport source (output valid, best_move, best_score, found, child_count, input ready);
  modport sink (input valid, best_move, best_score, found, child_count, output ready);
endinterface
`default_nettype wire

// File: rtl/psel_sqrt.sv
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module psel_sqrt (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [psel_pkg::SQ_IN_W-1:0]   rad,
  output logic      [psel_pkg::SQ_OUT_W-1:0]  root,
  output logic                                done
);
  localparam int CW = $clog2(psel_pkg::SQ_OUT_W);

  logic [psel_pkg::SQ_IN_W-1:0]  rad_r;
  logic [psel_pkg::SQ_OUT_W+2:0] rem_r;
  logic [psel_pkg::SQ_OUT_W-1:0] root_r;
  logic [CW-1:0]                 cnt_r;
  logic                          busy_r, done_r;
  logic [psel_pkg::SQ_OUT_W+2:0] t, trial;

  assign t     = {rem_r[psel_pkg::SQ_OUT_W:0], rad_r[psel_pkg::SQ_IN_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[psel_pkg::SQ_IN_W-3:0], 2'b00};
      if (t >= trial) begin
        rem_r  <= t - trial;
        root_r <= {root_r[psel_pkg::SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem_r  <= t;
        root_r <= {root_r[psel_pkg::SQ_OUT_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r + CW'(1);
      if (cnt_r == CW'(psel_pkg::SQ_OUT_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign root = root_r;
  assign done = done_r;
endmodule
`default_nettype wire

// File: rtl/psel_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module psel_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [psel_pkg::DVD_W-1:0]   dividend,
  input  wire logic [psel_pkg::DVS_W-1:0]   divisor,
  output logic      [psel_pkg::DVD_W-1:0]   quotient,
  output logic                              done,
  output logic                              busy
);
  localparam int CW = $clog2(psel_pkg::DVD_W);

  logic [psel_pkg::DVD_W-1:0] dvd_r;
  logic [psel_pkg::DVS_W-1:0] dvs_r, rem_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r, done_r;
  logic [psel_pkg::DVS_W:0]   t;

  assign t = {rem_r, dvd_r[psel_pkg::DVD_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
      dvd_r  <= dividend;
      dvs_r  <= divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      if (t >= {1'b0, dvs_r}) begin
        rem_r <= psel_pkg::DVS_W'(t - {1'b0, dvs_r});
        dvd_r <= {dvd_r[psel_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= t[psel_pkg::DVS_W-1:0];
        dvd_r <= {dvd_r[psel_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r + CW'(1);
      if (cnt_r == CW'(psel_pkg::DVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quotient = dvd_r;
  assign done     = done_r;
  assign busy     = busy_r;
endmodule
`default_nettype wire

// File: rtl/psel_dp.sv
// Datapath: child store, prior sum, square roots, divider, scoring and best tracking.
`default_nettype none
module psel_dp #(
  parameter int MAX_CHILDREN = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire psel_pkg::psel_cmd_t                   cmd,
  output psel_pkg::psel_sts_t                        sts,
  input  wire logic                                  cfg_we,
  input  wire logic [psel_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [psel_pkg::GAIN_W-1:0]           cfg_data,
  input  wire logic [psel_pkg::VIS_W-1:0]            parent_visits,
  input  wire logic signed [psel_pkg::TOT_W-1:0]     parent_total,
  input  wire logic [psel_pkg::MOVE_W-1:0]           move_id,
  input  wire logic [psel_pkg::PRIOR_W-1:0]          prior,
  input  wire logic [psel_pkg::VIS_W-1:0]            child_visits,
  input  wire logic signed [psel_pkg::TOT_W-1:0]     child_total,
  input  wire logic [psel_pkg::INF_W-1:0]            pending_vis,
  output logic      [psel_pkg::MOVE_W-1:0]           best_move,
  output logic signed [psel_pkg::SCORE_W-1:0]        best_score,
  output logic                                       found,
  output logic      [psel_pkg::CNTO_W-1:0]           child_count
);
  localparam int AW    = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
  localparam int CNT_W = $clog2(MAX_CHILDREN + 1);
  localparam int W     = psel_pkg::EXT_W;

  psel_pkg::child_t mem [MAX_CHILDREN];
  psel_pkg::child_t rd_q_r;

  logic [psel_pkg::GAIN_W-1:0]   explore_r, fpu_r;
  logic [CNT_W-1:0]              cnt_r, idx_r;
  logic [psel_pkg::VIS_W-1:0]    pvis_r;
  logic signed [psel_pkg::TOT_W-1:0] ptot_r;
  logic [psel_pkg::ACC_W-1:0]    acc_r;
  logic [psel_pkg::SUM_W-1:0]    sum_sat;
  logic [psel_pkg::SQ_OUT_W-1:0] sq_root, sq_s_r, sq_n_r;
  logic [psel_pkg::SQ_IN_W-1:0]  sq_rad;
  logic [psel_pkg::R_W-1:0]      r_r;
  logic [psel_pkg::E_W-1:0]      e_r;
  logic [W-1:0]                  prod_r;
  logic [psel_pkg::U_W-1:0]      u_r;
  logic signed [W-1:0]           pq_r, eq_r, best_r, exploit, score;
  logic [psel_pkg::MOVE_W-1:0]   best_move_r;
  logic                          best_valid_r;
  logic [psel_pkg::DVD_W-1:0]    dvd, quot;
  logic [psel_pkg::DVS_W-1:0]    dvs;
  logic signed [W-1:0]           pt48, ct48, pabs, cabs;
  logic [W-1:0]                  qmag;
  logic                          div_done, div_busy, sq_done;
  logic [psel_pkg::MOVE_W-1:0]   om_r;
  logic signed [psel_pkg::SCORE_W-1:0] os_r;
  logic                          of_r;
  logic [psel_pkg::CNTO_W-1:0]   oc_r;
  logic [10:0]                   cnt_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      explore_r <= psel_pkg::EXPLORE_RST;
      fpu_r     <= psel_pkg::FPU_RST;
    end else if (cfg_we) begin
      if (cfg_index == psel_pkg::CFG_EXPLORE) explore_r <= cfg_data;
      if (cfg_index == psel_pkg::CFG_FPU) fpu_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_child && (cnt_r < CNT_W'(MAX_CHILDREN))) begin
      mem[cnt_r[AW-1:0]] <= '{move: move_id, prior: prior, visits: child_visits,
                              total: child_total, inflight: pending_vis};
    end
    rd_q_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pvis_r <= '0;
      ptot_r <= '0;
    end else begin
      if (cmd.load_hdr) begin
        pvis_r <= parent_visits;
        ptot_r <= parent_total;
      end
      if (cmd.load_hdr || cmd.clr_count) cnt_r <= '0;
      else if (cmd.store_child && (cnt_r < CNT_W'(MAX_CHILDREN))) cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + CNT_W'(1);
    if (cmd.sum_clr) acc_r <= '0;
    else if (cmd.sum_acc && (rd_q_r.visits != '0))
      acc_r <= acc_r + psel_pkg::ACC_W'(rd_q_r.prior);
  end

  assign sum_sat = (acc_r > psel_pkg::SUM_MAX) ? '1 : acc_r[psel_pkg::SUM_W-1:0];
  assign sq_rad  = cmd.sqrt_sel_n ? {pvis_r, 32'd0}
                                  : psel_pkg::SQ_IN_W'({sum_sat, 17'd0});

  psel_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.sqrt_start), .rad(sq_rad),
    .root(sq_root), .done(sq_done)
  );

  assign pt48 = W'(ptot_r);
  assign ct48 = W'($signed(rd_q_r.total));
  assign pabs = pt48[W-1] ? -pt48 : pt48;
  assign cabs = ct48[W-1] ? -ct48 : ct48;

  always_comb begin
    unique case (cmd.div_sel)
      psel_pkg::DIV_PQ: begin
        dvd = pabs;
        dvs = psel_pkg::DVS_W'(pvis_r);
      end
      psel_pkg::DIV_U: begin
        dvd = prod_r;
        dvs = psel_pkg::DVS_W'(rd_q_r.visits) + psel_pkg::DVS_W'(rd_q_r.inflight)
              + psel_pkg::DVS_W'(1);
      end
      psel_pkg::DIV_Q: begin
        dvd = cabs;
        dvs = psel_pkg::DVS_W'(rd_q_r.visits);
      end
      default: begin
        dvd = '0;
        dvs = psel_pkg::DVS_W'(1);
      end
    endcase
  end

  psel_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(dvd), .divisor(dvs),
    .quotient(quot), .done(div_done), .busy(div_busy)
  );

  assign qmag = quot;

  always_ff @(posedge clk) begin
    if (cmd.sq_s_ld) sq_s_r <= sq_root;
    if (cmd.sq_n_ld) sq_n_r <= sq_root;
    if (cmd.gain_ld) begin
      r_r <= psel_pkg::R_W'((37'(fpu_r) * 37'(sq_s_r[psel_pkg::SQS_W-1:0])) >> 12);
      e_r <= psel_pkg::E_W'((44'(explore_r) * 44'(sq_n_r)) >> 12);
    end
    if (cmd.pq_ld)
      pq_r <= (pvis_r == '0) ? '0 : (pt48[W-1] ? -$signed(qmag) : $signed(qmag));
    if (cmd.prod_ld) prod_r <= W'(e_r) * W'(rd_q_r.prior);
    if (cmd.u_ld) u_r <= psel_pkg::U_W'(quot >> 15);
    if (cmd.q_ld) eq_r <= ct48[W-1] ? $signed(qmag) : -$signed(qmag);
  end

  assign exploit = (rd_q_r.visits == '0) ? (pq_r - $signed(W'(r_r))) : eq_r;
  assign score   = exploit + $signed(W'(u_r));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.best_clr) begin
      best_r       <= psel_pkg::SENTINEL;
      best_move_r  <= '0;
      best_valid_r <= 1'b0;
    end else if (cmd.cmp && (score > best_r)) begin
      best_r       <= score;
      best_move_r  <= rd_q_r.move;
      best_valid_r <= 1'b1;
    end
  end

  assign cnt_ext = 11'(cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      of_r <= best_valid_r;
      om_r <= best_valid_r ? best_move_r : '0;
      if (!best_valid_r) os_r <= '0;
      else if (best_r > W'(32'sh7FFF_FFFF)) os_r <= 32'sh7FFF_FFFF;
      else if (best_r < -W'(64'sd2147483648)) os_r <= 32'sh8000_0000;
      else os_r <= best_r[psel_pkg::SCORE_W-1:0];
      oc_r <= (cnt_ext > 11'd511) ? 9'd511 : cnt_ext[psel_pkg::CNTO_W-1:0];
    end
  end

  assign best_move   = om_r;
  assign best_score  = os_r;
  assign found       = of_r;
  assign child_count = oc_r;

  assign sts.sqrt_done = sq_done;
  assign sts.div_done  = div_done;
  assign sts.div_busy  = div_busy;
  assign sts.idx_last  = (idx_r == cnt_r - CNT_W'(1));
  assign sts.visited   = (rd_q_r.visits != '0);
endmodule
`default_nettype wire

// File: rtl/psel_ctrl.sv
// Controller: request handshake, pass sequencing and result handshake.
`default_nettype none
module psel_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_cmd,
  input  wire logic                in_last,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output psel_pkg::psel_cmd_t      cmd,
  input  wire psel_pkg::psel_sts_t sts
);
  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_SUM_RD  = 14'b00000000000010,
    S_SUM_ACC = 14'b00000000000100,
    S_SQ_GO   = 14'b00000000001000,
    S_SQS     = 14'b00000000010000,
    S_SQN     = 14'b00000000100000,
    S_PQ      = 14'b00000001000000,
    S_CH_RD   = 14'b00000010000000,
    S_CH_MUL  = 14'b00000100000000,
    S_CH_DU   = 14'b00001000000000,
    S_CH_WU   = 14'b00010000000000,
    S_CH_WQ   = 14'b00100000000000,
    S_CH_CMP  = 14'b01000000000000,
    S_FIN     = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.div_sel   = psel_pkg::DIV_PQ;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_cmd) begin
            cmd.load_hdr = 1'b1;
          end else begin
            cmd.store_child = 1'b1;
            if (in_last) begin
              cmd.idx_clr = 1'b1;
              cmd.sum_clr = 1'b1;
              state_nxt   = S_SUM_RD;
            end
          end
        end
      end
      S_SUM_RD: state_nxt = S_SUM_ACC;
      S_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_SQ_GO;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SUM_RD;
        end
      end
      S_SQ_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_SQS;
      end
      S_SQS: begin
        if (sts.sqrt_done) begin
          cmd.sq_s_ld    = 1'b1;
          cmd.sqrt_start = 1'b1;
          cmd.sqrt_sel_n = 1'b1;
          state_nxt      = S_SQN;
        end
      end
      S_SQN: begin
        if (sts.sqrt_done) begin
          cmd.sq_n_ld   = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_PQ;
        end
      end
      S_PQ: begin
        if (sts.div_done) begin
          cmd.pq_ld    = 1'b1;
          cmd.gain_ld  = 1'b1;
          cmd.best_clr = 1'b1;
          state_nxt    = S_CH_RD;
        end
      end
      S_CH_RD: state_nxt = S_CH_MUL;
      S_CH_MUL: begin
        cmd.prod_ld = 1'b1;
        state_nxt   = S_CH_DU;
      end
      S_CH_DU: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = psel_pkg::DIV_U;
        state_nxt     = S_CH_WU;
      end
      S_CH_WU: begin
        if (sts.div_done) begin
          cmd.u_ld = 1'b1;
          if (sts.visited) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = psel_pkg::DIV_Q;
            state_nxt     = S_CH_WQ;
          end else begin
            state_nxt = S_CH_CMP;
          end
        end
      end
      S_CH_WQ: begin
        if (sts.div_done) begin
          cmd.q_ld  = 1'b1;
          state_nxt = S_CH_CMP;
        end
      end
      S_CH_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.idx_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CH_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          cmd.clr_count = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

// File: rtl/puct_child_selector_unit.sv
// PUCT child selector with first-play urgency. A header request (cmd 0) latches the
// parent visit count and total; child requests (cmd 1) are stored one per cycle while
// the unit is idle, up to MAX_CHILDREN. The child flagged last_child starts the
// selection: a sum pass over the stored children, two square roots, the parent value
// division, and a scoring pass that runs the shared one-bit-per-cycle divider once per
// unvisited child and twice per visited child. The result register frees the request
// side once loaded, so a new header or child may arrive while it waits.
`default_nettype none
module puct_child_selector_unit #(
  parameter int MAX_CHILDREN = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  psel_in_if.sink                               in_ch,
  psel_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [psel_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [psel_pkg::GAIN_W-1:0]      cfg_data
);
  psel_pkg::psel_cmd_t cmd;
  psel_pkg::psel_sts_t sts;

  psel_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_cmd(in_ch.cmd), .in_last(in_ch.last_child),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  psel_dp #(.MAX_CHILDREN(MAX_CHILDREN)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .parent_visits(in_ch.parent_visits), .parent_total(in_ch.parent_total),
    .move_id(in_ch.move_id), .prior(in_ch.prior),
    .child_visits(in_ch.child_visits), .child_total(in_ch.child_total),
    .pending_vis(in_ch.pending_vis),
    .best_move(out_ch.best_move), .best_score(out_ch.best_score),
    .found(out_ch.found), .child_count(out_ch.child_count)
  );

  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.found && (out_ch.child_count != '0)))
    else $error("result without a winning child");

  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !sts.div_busy)
    else $error("request accepted while divider busy");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> sts.div_busy)
    else $error("divider did not start");
endmodule
`default_nettype wire
